FILE: src/med_pixel_predictor_defines.svh
// ----------------------------------------------------------------------------
// med_pixel_predictor_defines
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef MED_PIXEL_PREDICTOR_DEFINES_SVH
`define MED_PIXEL_PREDICTOR_DEFINES_SVH

// implication checked out of reset
`define MPP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked out of reset
`define MPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define MPP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared widths, register indexes and queue item type of the MED predictor.
// ----------------------------------------------------------------------------
package mpp_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 13;
  localparam int COL_W         = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int DIM_LIMIT     = 4096;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int QDEPTH        = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             first_col;
    logic             frame_end;
  } item_t;

endpackage

FILE: src/mpp_front.sv
// ----------------------------------------------------------------------------
// mpp_front
// Holds the frame size, tracks raster position and tags each pixel request.
// ----------------------------------------------------------------------------
module mpp_front #(
  parameter int MAX_WIDTH = mpp_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpp_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mpp_pkg::PIX_W-1:0]       in_pixel,
  output logic                            push,
  output mpp_pkg::item_t                  push_item,
  input  logic                            q_full
);
  import mpp_pkg::*;

  localparam int WMAX = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam logic [CFG_W-1:0] WMAX_C = CFG_W'(WMAX);
  localparam logic [CFG_W-1:0] HMAX_C = CFG_W'(DIM_LIMIT);

  logic [COL_W-1:0] width_last_r, height_last_r;
  logic [COL_W-1:0] col_r, row_r;
  logic [COL_W-1:0] width_last_nxt, height_last_nxt;
  logic             last_col, last_row;

  always_comb begin
    if (cfg_wdata == '0) begin
      width_last_nxt  = '0;
      height_last_nxt = '0;
    end else begin
      width_last_nxt  = (cfg_wdata > WMAX_C) ? COL_W'(WMAX_C - 1'b1)
                                             : COL_W'(cfg_wdata - 1'b1);
      height_last_nxt = (cfg_wdata > HMAX_C) ? COL_W'(HMAX_C - 1'b1)
                                             : COL_W'(cfg_wdata - 1'b1);
    end
  end

  assign in_stall  = q_full;
  assign push      = in_valid & ~q_full;
  assign last_col  = (col_r == width_last_r);
  assign last_row  = (row_r == height_last_r);

  assign push_item.pixel     = in_pixel;
  assign push_item.col       = col_r;
  assign push_item.first_row = (row_r == '0);
  assign push_item.first_col = (col_r == '0);
  assign push_item.frame_end = last_col & last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= COL_W'(WMAX_C - 1'b1);
      height_last_r <= COL_W'(HMAX_C - 1'b1);
      col_r         <= '0;
      row_r         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_last_r  <= width_last_nxt;
        CFG_IMAGE_HEIGHT: height_last_r <= height_last_nxt;
        default:          ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

endmodule

FILE: src/mpp_fifo.sv
// ----------------------------------------------------------------------------
// mpp_fifo
// Two-entry queue of tagged pixel requests between front and back.
// ----------------------------------------------------------------------------
module mpp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mpp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output mpp_pkg::item_t q_item
);
  import mpp_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  item_t           store_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full    = (count_r == (PW+1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_item;
  end

endmodule

FILE: src/mpp_back.sv
// ----------------------------------------------------------------------------
// mpp_back
// Line buffer lookup, MED prediction and output register.
// ----------------------------------------------------------------------------
module mpp_back #(
  parameter int MAX_WIDTH = mpp_pkg::DEF_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  mpp_pkg::item_t            q_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mpp_pkg::PIX_W-1:0] out_prediction,
  output logic                      out_frame_end
);
  import mpp_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [31:0]      col_ext;
  logic [AW-1:0]    addr;

  logic             s1_v_r, out_v_r;
  item_t            s1_item_r;
  logic [PIX_W-1:0] up_r, left_r, ul_r;
  logic [PIX_W-1:0] out_pred_r;
  logic             out_fe_r;
  logic             s1_go;
  logic [PIX_W-1:0] lo, hi, pred_nxt;
  logic [PIX_W+1:0] grad;

  assign col_ext = 32'(q_item.col);
  assign addr    = col_ext[AW-1:0];

  assign s1_go = s1_v_r & (~out_v_r | ~out_stall);
  assign pop   = q_valid & (~s1_v_r | s1_go);

  // left = left_r, upper-left = ul_r, upper = up_r
  always_comb begin
    lo   = (left_r < up_r) ? left_r : up_r;
    hi   = (left_r < up_r) ? up_r : left_r;
    grad = {2'b00, left_r} + {2'b00, up_r} - {2'b00, ul_r};
    if (s1_item_r.first_row && s1_item_r.first_col) begin
      pred_nxt = s1_item_r.pixel;
    end else if (s1_item_r.first_row) begin
      pred_nxt = left_r;
    end else if (s1_item_r.first_col) begin
      pred_nxt = up_r;
    end else if (ul_r >= hi) begin
      pred_nxt = lo;
    end else if (ul_r <= lo) begin
      pred_nxt = hi;
    end else begin
      pred_nxt = grad[PIX_W-1:0];
    end
  end

  // read-before-write: the request sees the previous row's value
  always_ff @(posedge clk) begin
    if (pop) begin
      up_r           <= line_mem[addr];
      line_mem[addr] <= q_item.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      left_r  <= '0;
      ul_r    <= '0;
    end else begin
      if (pop)        s1_v_r <= 1'b1;
      else if (s1_go) s1_v_r <= 1'b0;
      if (s1_go)                 out_v_r <= 1'b1;
      else if (~out_stall)       out_v_r <= 1'b0;
      if (s1_go) begin
        left_r <= s1_item_r.pixel;
        ul_r   <= up_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1_item_r <= q_item;
    if (s1_go) begin
      out_pred_r <= pred_nxt;
      out_fe_r   <= s1_item_r.frame_end;
    end
  end

  assign out_valid      = out_v_r;
  assign out_prediction = out_pred_r;
  assign out_frame_end  = out_fe_r;

endmodule

FILE: src/med_pixel_predictor.sv
// ----------------------------------------------------------------------------
// med_pixel_predictor
// LOCO-I median edge detector predictor for 8-bit grey raster pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one prediction per clock while the
// output is not stalled; an accepted request passes through the queue, the
// stage-1 register and the output register. The single-port line buffer is
// read and written once per request (read before write), which sets the
// one-pixel-per-clock rate. A two-entry queue and an output register keep
// input accepted while a result waits to be taken. Writing either size
// register restarts the frame at row 0, column 0.
module med_pixel_predictor #(
  parameter int MAX_WIDTH = mpp_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpp_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpp_pkg::PIX_W-1:0]     out_prediction,
  output logic                          out_frame_end
);
  import mpp_pkg::*;

  logic  push, q_full, pop, q_valid;
  item_t push_item, q_item;

  mpp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  mpp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  mpp_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prediction (out_prediction),
    .out_frame_end  (out_frame_end)
  );

endmodule

FILE: src/mpp_checker.sv
// ----------------------------------------------------------------------------
// mpp_checker
// Port-level checks of the MED predictor, bound to the top level.
// ----------------------------------------------------------------------------
`include "med_pixel_predictor_defines.svh"

module mpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mpp_pkg::PIX_W-1:0]     out_prediction,
  input logic                          out_frame_end
);

  `MPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_prediction) && $stable(out_frame_end), "stalled result changed")

  `MPP_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "result valid after reset")

  `MPP_ASSERT(a_no_stall_empty, !out_valid, !in_stall, "input stalled with empty output")

  `MPP_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid, "accepted request not delivered")

endmodule

bind med_pixel_predictor mpp_checker u_mpp_checker (.*);

FILE: tb/med_pixel_predictor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// med_pixel_predictor_tb
// Self-checking testbench of the MED pixel predictor.
// ----------------------------------------------------------------------------
// A directed table covers reset sizes, first row and first column, all three
// median cases, frame wrap and the zero frame sizes. Phases with oversized and
// then random frame sizes follow, each writing one or both sizes and sending a
// random pixel stream. Every accepted request is run through a bit-accurate
// predictor in the testbench, and each result is checked in order against the
// oldest pending prediction. Both sides idle at random.
module med_pixel_predictor_tb;
  import mpp_pkg::*;

  localparam int LIMIT       = 2_000_000;
  localparam int RAND_PIXELS = 1100;

  typedef struct packed {
    logic [PIX_W-1:0] pred;
    logic             fend;
  } pred_t;

  typedef struct packed {
    logic             typed;
    logic [PIX_W-1:0] pred;
    logic             fend;
  } known_t;

  typedef struct {
    bit               wr;
    cfg_idx_t         idx;
    logic [CFG_W-1:0] val;
    logic [PIX_W-1:0] px;
    known_t           known;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_prediction;
  logic             out_frame_end;

  // predictor state
  logic [PIX_W-1:0] row_mem [DIM_LIMIT];
  logic [PIX_W-1:0] left_px = '0;
  logic [PIX_W-1:0] upleft_px = '0;
  int unsigned      col_cnt = 0;
  int unsigned      row_cnt = 0;
  logic [CFG_W-1:0] width_reg = CFG_W'(DIM_LIMIT);
  logic [CFG_W-1:0] height_reg = CFG_W'(DIM_LIMIT);

  pred_t            pred_q [$];
  known_t           known_q [$];
  dir_row_t         dir_tbl [$];
  int               err_cnt = 0;
  int               cyc = 0;
  bit               calm = 1'b0;
  logic [PIX_W-1:0] last_px = '0;

  always #1 clk = ~clk;

  med_pixel_predictor u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prediction(out_prediction),
    .out_frame_end (out_frame_end)
  );

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  // MED prediction for one pixel; advances the raster position
  function automatic pred_t med_predict(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    int unsigned      row;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    bit               last_col;
    bit               last_row;
    pred_t            res;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    col = (col_cnt >= w) ? w - 1 : col_cnt;
    row = (row_cnt >= h) ? h - 1 : row_cnt;
    up = row_mem[col[COL_W-1:0]];
    lo = (left_px < up) ? left_px : up;
    hi = (left_px < up) ? up : left_px;
    if (row == 0 && col == 0) res.pred = px;
    else if (row == 0) res.pred = left_px;
    else if (col == 0) res.pred = up;
    else if (upleft_px >= hi) res.pred = lo;
    else if (upleft_px <= lo) res.pred = hi;
    else res.pred = left_px + up - upleft_px;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    res.fend = last_col && last_row;
    upleft_px = up;
    row_mem[col[COL_W-1:0]] = px;
    left_px = px;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] gen_pixel();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3, 4: v = last_px + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
      default: v = PIX_W'($urandom);
    endcase
    last_px = v;
    return v;
  endfunction

  function automatic void add_pix(input logic [PIX_W-1:0] px, input bit typed,
                                  input logic [PIX_W-1:0] pred, input bit fend);
    dir_row_t r;
    r.wr = 1'b0;
    r.idx = CFG_IMAGE_WIDTH;
    r.val = '0;
    r.px = px;
    r.known = '{typed, pred, fend};
    dir_tbl.push_back(r);
  endfunction

  function automatic void add_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    dir_row_t r;
    r.wr = 1'b1;
    r.idx = idx;
    r.val = val;
    r.px = '0;
    r.known = '0;
    dir_tbl.push_back(r);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input known_t known);
    int n;
    n = idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    known_q.push_back(known);
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    col_cnt = 0;
    row_cnt = 0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input bit wr_w, input bit wr_h, input int n);
    if (wr_w) write_reg(CFG_IMAGE_WIDTH, w);
    if (wr_h) write_reg(CFG_IMAGE_HEIGHT, h);
    calm = ($urandom_range(0, 4) == 0);
    repeat (n) send_pixel(gen_pixel(), '0);
  endtask

  // request acceptance, prediction and result check
  always @(posedge clk) begin
    known_t k;
    pred_t  p;
    pred_t  e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        k = known_q.pop_front();
        p = med_predict(in_pixel);
        if (k.typed) p = '{k.pred, k.fend};
        pred_q.push_back(p);
      end
      if (out_valid && !out_stall) begin
        if (pred_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result pred=%0d end=%0b",
                                    out_prediction, out_frame_end));
        end else begin
          e = pred_q.pop_front();
          if (out_prediction !== e.pred)
            report_mismatch($sformatf("prediction got %0d exp %0d",
                                      out_prediction, e.pred));
          if (out_frame_end !== e.fend)
            report_mismatch($sformatf("frame_end got %0b exp %0b",
                                      out_frame_end, e.fend));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    int r;
    foreach (row_mem[i]) row_mem[i] = '0;

    // reset sizes: first pixel, then first row
    add_pix(8'hA5, 1'b1, 8'hA5, 1'b0);
    add_pix(8'h00, 1'b1, 8'hA5, 1'b0);
    // 3x3 frame: first row, first column, median cases
    add_cfg(CFG_IMAGE_WIDTH, 13'd3);
    add_cfg(CFG_IMAGE_HEIGHT, 13'd3);
    add_pix(8'd10, 1'b1, 8'd10, 1'b0);
    add_pix(8'd200, 1'b1, 8'd10, 1'b0);
    add_pix(8'd255, 1'b1, 8'd200, 1'b0);
    add_pix(8'd0, 1'b1, 8'd10, 1'b0);
    add_pix(8'd50, 1'b0, '0, 1'b0);
    add_pix(8'd255, 1'b0, '0, 1'b0);
    add_pix(8'd255, 1'b1, 8'd0, 1'b0);
    add_pix(8'd0, 1'b0, '0, 1'b0);
    add_pix(8'd128, 1'b0, '0, 1'b0);
    // wrap into the next frame; upper-left above both neighbors
    add_pix(8'd0, 1'b1, 8'd0, 1'b0);
    add_pix(8'd255, 1'b1, 8'd0, 1'b0);
    add_pix(8'd0, 1'b1, 8'd255, 1'b0);
    add_pix(8'd255, 1'b1, 8'd0, 1'b0);
    add_pix(8'd100, 1'b0, '0, 1'b0);
    add_pix(8'd7, 1'b0, '0, 1'b0);
    // zero sizes read as one: every pixel is a whole frame
    add_cfg(CFG_IMAGE_WIDTH, 13'd0);
    add_cfg(CFG_IMAGE_HEIGHT, 13'd0);
    add_pix(8'd77, 1'b1, 8'd77, 1'b1);
    add_pix(8'd255, 1'b1, 8'd255, 1'b1);
    // single column, two rows
    add_cfg(CFG_IMAGE_WIDTH, 13'd1);
    add_cfg(CFG_IMAGE_HEIGHT, 13'd2);
    add_pix(8'd0, 1'b1, 8'd0, 1'b0);
    add_pix(8'd200, 1'b1, 8'd0, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].wr) write_reg(dir_tbl[i].idx, dir_tbl[i].val);
      else send_pixel(dir_tbl[i].px, dir_tbl[i].known);
    end

    // oversized sizes saturate
    run_phase(13'h1FFF, 13'd1, 1'b1, 1'b1, 40);
    run_phase(13'd4097, 13'h1FFF, 1'b1, 1'b1, 40);
    run_phase(13'd0, 13'h1FFF, 1'b1, 1'b1, 40);
    run_phase(13'd4096, 13'd4096, 1'b1, 1'b1, 30);

    sent = 0;
    while (sent < RAND_PIXELS) begin
      r = $urandom_range(0, 3);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
      run_phase(CFG_W'($urandom_range(1, 9)), CFG_W'($urandom_range(1, 6)),
                r != 1, r != 0, n);
      sent += n;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
